// ===== src/ibs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types and codes for the ignition burn sequencer.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int TIME_WIDTH_DEF   = 16;
  localparam int DRIVER_COUNT_DEF = 6;

  localparam int CMD_W       = 3;
  localparam int DRV_IDX_W   = 3;
  localparam int DRV_BITS_W  = 6;
  localparam int CAUSE_W     = 2;
  localparam int CFG_IDX_W   = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

  // End-of-burn causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_TIME = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_TRIP = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_STOP = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BURN_MS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_LEAD_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTOFF_DELAY_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTOFF_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_VALVE_USED  = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [DRV_IDX_W-1:0] driver_index;
    logic                 pressure_trip;
  } ibs_in_t;

  typedef struct packed {
    logic [DRV_BITS_W-1:0] driver_bits;
    logic                  igniter_on;
    logic                  main_valve_open;
    logic                  burning;
    logic [CAUSE_W-1:0]    end_cause;
  } ibs_out_t;

  // Burn control flags carried between the top level and the step logic
  typedef struct packed {
    logic burn_active;
    logic valve_opened;
    logic pressure_latched;
  } ibs_flags_t;

  typedef struct packed {
    logic shutoff_enable;
    logic main_valve_used;
  } ibs_cfg_flags_t;

endpackage

// ===== src/ibs_step.sv =====
// ----------------------------------------------------------------------------
// ibs_step
// Next-state and result logic for one command against the burn state.
// ----------------------------------------------------------------------------
module ibs_step import ibs_pkg::*; #(
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int DRIVER_COUNT = DRIVER_COUNT_DEF
) (
  input  ibs_in_t                  item,
  input  ibs_cfg_flags_t           cfg_flags,
  input  logic [TIME_WIDTH-1:0]    burn_ms,
  input  logic [TIME_WIDTH-1:0]    valve_lead_ms,
  input  logic [TIME_WIDTH-1:0]    shutoff_delay_ms,
  input  ibs_flags_t               flags,
  input  logic [TIME_WIDTH-1:0]    elapsed,
  input  logic [DRIVER_COUNT-1:0]  drivers,
  output ibs_flags_t               flags_nxt,
  output logic [TIME_WIDTH-1:0]    elapsed_nxt,
  output logic [DRIVER_COUNT-1:0]  drivers_nxt,
  output ibs_out_t                 result
);

  localparam int EXT_W = (DRIVER_COUNT > DRV_BITS_W) ? DRIVER_COUNT : DRV_BITS_W;

  ibs_flags_t            f;
  logic [TIME_WIDTH-1:0] el;
  logic [CAUSE_W-1:0]    cause;
  logic [EXT_W-1:0]      drv_ext;

  always_comb begin
    f           = flags;
    el          = elapsed;
    drivers_nxt = drivers;
    cause       = CAUSE_NONE;

    if (item.cmd == CMD_START) begin
      f.pressure_latched = 1'b0;
    end else if (item.pressure_trip) begin
      f.pressure_latched = 1'b1;
    end

    case (item.cmd)
      CMD_TICK: begin
        if (f.burn_active && (el != {TIME_WIDTH{1'b1}})) begin
          el = el + TIME_WIDTH'(1);
        end
      end
      CMD_SET, CMD_CLEAR: begin
        for (int i = 0; i < DRIVER_COUNT; i++) begin
          if (int'(item.driver_index) == i) begin
            drivers_nxt[i] = (item.cmd == CMD_SET);
          end
        end
      end
      CMD_START: begin
        if (!f.burn_active) begin
          f.burn_active  = 1'b1;
          f.valve_opened = 1'b0;
          el             = '0;
        end
      end
      CMD_STOP: begin
        if (f.burn_active) begin
          f.burn_active  = 1'b0;
          f.valve_opened = 1'b0;
          cause          = CAUSE_STOP;
        end
      end
      default: ;
    endcase

    // burn checks run on every item, tick or not
    if (f.burn_active) begin
      if (el >= burn_ms) begin
        f.burn_active  = 1'b0;
        f.valve_opened = 1'b0;
        cause          = CAUSE_TIME;
      end else begin
        if (!f.valve_opened && cfg_flags.main_valve_used && (el > valve_lead_ms)) begin
          f.valve_opened = 1'b1;
        end
        if (cfg_flags.shutoff_enable && f.pressure_latched && (el > shutoff_delay_ms)) begin
          f.burn_active  = 1'b0;
          f.valve_opened = 1'b0;
          cause          = CAUSE_TRIP;
        end
      end
    end

    flags_nxt   = f;
    elapsed_nxt = el;
  end

  assign drv_ext = EXT_W'(drivers_nxt);

  assign result.driver_bits     = drv_ext[DRV_BITS_W-1:0];
  assign result.igniter_on      = flags_nxt.burn_active;
  assign result.main_valve_open = flags_nxt.valve_opened;
  assign result.burning         = flags_nxt.burn_active;
  assign result.end_cause       = cause;

endmodule

// ===== src/ignition_burn_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ignition_burn_sequencer_unit
// Timed burn sequencer with igniter, main valve and a bank of driver outputs.
// ----------------------------------------------------------------------------
// One command is taken per cycle and gives exactly one result. A transfer is
// captured in an input register, evaluated against the burn state in one pass
// of compare/increment logic, and lands in the result register, from which
// it is presented on out_data and held until out_ready takes it. Throughput
// is one item per clock; it drops only while the result register is held by
// out_ready low.
// Configuration writes take effect on the next cycle and belong between bursts.
module ignition_burn_sequencer_unit import ibs_pkg::*; #(
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int DRIVER_COUNT = DRIVER_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ibs_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ibs_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_WIDTH-1:0] cfg_wdata
);

  // configuration
  logic [TIME_WIDTH-1:0] burn_ms_r;
  logic [TIME_WIDTH-1:0] valve_lead_ms_r;
  logic [TIME_WIDTH-1:0] shutoff_delay_ms_r;
  ibs_cfg_flags_t        cfg_flags_r;

  // burn state
  ibs_flags_t              flags_r, flags_nxt;
  logic [TIME_WIDTH-1:0]   elapsed_r, elapsed_nxt;
  logic [DRIVER_COUNT-1:0] drivers_r, drivers_nxt;

  // pipeline
  logic     s1_valid_r;
  ibs_in_t  s1_data_r;
  logic     out_valid_r;
  ibs_out_t out_data_r;
  ibs_out_t result;
  logic     s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burn_ms_r                   <= '0;
      valve_lead_ms_r             <= '0;
      shutoff_delay_ms_r          <= '0;
      cfg_flags_r.shutoff_enable  <= 1'b0;
      cfg_flags_r.main_valve_used <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BURN_MS:          burn_ms_r                   <= cfg_wdata;
        REG_VALVE_LEAD_MS:    valve_lead_ms_r             <= cfg_wdata;
        REG_SHUTOFF_DELAY_MS: shutoff_delay_ms_r          <= cfg_wdata;
        REG_SHUTOFF_ENABLE:   cfg_flags_r.shutoff_enable  <= cfg_wdata[0];
        REG_MAIN_VALVE_USED:  cfg_flags_r.main_valve_used <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  ibs_step #(
    .TIME_WIDTH   (TIME_WIDTH),
    .DRIVER_COUNT (DRIVER_COUNT)
  ) u_step (
    .item             (s1_data_r),
    .cfg_flags        (cfg_flags_r),
    .burn_ms          (burn_ms_r),
    .valve_lead_ms    (valve_lead_ms_r),
    .shutoff_delay_ms (shutoff_delay_ms_r),
    .flags            (flags_r),
    .elapsed          (elapsed_r),
    .drivers          (drivers_r),
    .flags_nxt        (flags_nxt),
    .elapsed_nxt      (elapsed_nxt),
    .drivers_nxt      (drivers_nxt),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      elapsed_r   <= '0;
      drivers_r   <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
        elapsed_r   <= elapsed_nxt;
        drivers_r   <= drivers_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a reported end cause always comes with the burn already off
  a_cause_ends_burn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.end_cause != CAUSE_NONE) |-> !out_data_r.burning)
    else $error("end cause reported while still burning");

  // valve is never shown open outside a burn
  a_valve_in_burn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.main_valve_open |-> out_data_r.burning)
    else $error("main valve open without a burn");

  // only a start may move the elapsed count backward
  a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_data_r.cmd != CMD_START) |-> elapsed_nxt >= elapsed_r)
    else $error("elapsed count went backward");

  // a held input stage must block new transfers
  a_stage_block: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |-> !in_ready)
    else $error("input accepted over a stalled stage");

endmodule
